FILE: src/wks_pkg.sv
package wks_pkg;

  localparam int NUM_KEYS    = 128;
  localparam int KEY_LEN_MAX = 32;

  localparam int POS_W = (KEY_LEN_MAX > 1) ? $clog2(KEY_LEN_MAX) : 1;
  localparam int LEN_W = $clog2(KEY_LEN_MAX + 1);
  localparam int SUM_W = (17 + $clog2(NUM_KEYS) > 24) ? 17 + $clog2(NUM_KEYS) : 24;

  localparam logic [1:0] OP_TEXT = 2'd0;
  localparam logic [1:0] OP_CHAR = 2'd1;
  localparam logic [1:0] OP_HDR  = 2'd2;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_KEY_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         byte_value;
    logic               is_last;
    logic [6:0]         entry_index;
    logic [4:0]         char_pos;
    logic signed [15:0] weight;
    logic [5:0]         key_length;
  } in_t;

  typedef struct packed {
    logic signed [23:0] score;
    logic               selected;
  } out_t;

  // Load data shared by every cell.
  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [7:0]         chr;
    logic signed [15:0] weight;
    logic [LEN_W-1:0]   len;
  } ld_data_t;

  // Per-cell control.
  typedef struct packed {
    logic char_we;
    logic hdr_we;
    logic match_en;
    logic active;
    logic clear;
  } cell_ctl_t;

endpackage

FILE: src/wks_cell.sv
module wks_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wks_pkg::cell_ctl_t               ctl,
  input  wks_pkg::ld_data_t                ld,
  input  logic [7:0]                       win [wks_pkg::KEY_LEN_MAX],
  input  logic [wks_pkg::LEN_W-1:0]        chars_seen,
  input  logic signed [wks_pkg::SUM_W-1:0] sum_in,
  output logic signed [wks_pkg::SUM_W-1:0] sum_out
);

  logic [7:0]                       chars_r [wks_pkg::KEY_LEN_MAX];
  logic [wks_pkg::LEN_W-1:0]        len_r;
  logic signed [15:0]               weight_r;
  logic                             found_r;
  logic                             found_nxt;
  logic                             hit;
  logic [wks_pkg::LEN_W-1:0]        wi;
  logic signed [wks_pkg::SUM_W-1:0] sum_r;
  logic signed [wks_pkg::SUM_W-1:0] sum_nxt;

  // Key character p lines up with the character received len-1-p bytes ago.
  always_comb begin
    hit = (chars_seen >= len_r);
    wi  = '0;
    for (int p = 0; p < wks_pkg::KEY_LEN_MAX; p++) begin
      if (wks_pkg::LEN_W'(p) < len_r) begin
        wi = len_r - wks_pkg::LEN_W'(p) - wks_pkg::LEN_W'(1);
        if (chars_r[p] != win[wi[wks_pkg::POS_W-1:0]]) begin
          hit = 1'b0;
        end
      end
    end
  end

  always_comb begin
    found_nxt = found_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (ctl.match_en && ctl.active && hit) begin
      found_nxt = 1'b1;
    end
  end

  always_comb begin
    sum_nxt = sum_in;
    if (found_r && ctl.active) begin
      sum_nxt = sum_in + wks_pkg::SUM_W'(weight_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (ctl.char_we) begin
      chars_r[ld.pos] <= ld.chr;
    end
    if (ctl.hdr_we) begin
      len_r    <= ld.len;
      weight_r <= ld.weight;
    end
  end

  assign sum_out = sum_r;

endmodule

FILE: src/weighted_keyword_score_filter.sv
// Weighted keyword score filter.
// The input channel carries one beat per text byte or table load (in_valid,
// in_stall, in_data). Text bytes are folded to upper case and shifted into a
// window; every active keyword cell compares its stored characters against
// that window in the cycle after the byte is taken and latches a found bit.
// Loads write a cell's characters, weight and length and are taken at one
// beat per cycle while idle. Ordinary text bytes are also taken at one beat
// per cycle while idle. On the text byte marked last the input stalls while
// the partial score ripples through the chain of NUM_KEYS cells, one cell per
// cycle, so a record end passes a match state and a summing state before
// its result appears on the output channel (out_valid, out_stall, out_data).
// The result sits in an output register; if the receiver stalls a finished
// record, the block keeps taking bytes of the next record and holds only
// when the next record's score is ready too. Configuration (threshold,
// key_count) is written through the cfg port, which is always ready.
// Synchronous reset clears the window, the found bits, both registers and all
// handshake state; the keyword table is undefined until loaded.
module weighted_keyword_score_filter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  wks_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output wks_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [23:0]   cfg_data
);

  localparam int CNT_W = $clog2(wks_pkg::NUM_KEYS + 1);
  localparam logic signed [wks_pkg::SUM_W-1:0] SAT_HI = wks_pkg::SUM_W'(8388607);
  localparam logic signed [wks_pkg::SUM_W-1:0] SAT_LO = -wks_pkg::SUM_W'(8388608);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MATCH = 3'b010,
    ST_SUM   = 3'b100
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      match_pend_r;
  logic signed [23:0]        threshold_r;
  logic [7:0]                key_count_r;
  logic [7:0]                win_r [wks_pkg::KEY_LEN_MAX];
  logic [wks_pkg::LEN_W-1:0] chars_seen_r;
  logic                      out_valid_r;
  wks_pkg::out_t             out_r;
  logic                      in_acc;
  logic                      is_text;
  logic                      finish;
  logic [7:0]                folded;
  wks_pkg::ld_data_t         ld;
  wks_pkg::cell_ctl_t        ctl [wks_pkg::NUM_KEYS];
  logic signed [wks_pkg::SUM_W-1:0] chain [wks_pkg::NUM_KEYS+1];
  logic signed [wks_pkg::SUM_W-1:0] total;
  logic signed [23:0]        score_sat;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign is_text   = (in_data.op == wks_pkg::OP_TEXT);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign folded = (in_data.byte_value >= 8'h61 && in_data.byte_value <= 8'h7a) ?
                  in_data.byte_value - 8'h20 : in_data.byte_value;

  // The chain end is ready once cnt_r reaches NUM_KEYS; it waits there if
  // the previous result has not been taken.
  assign finish = (state_r == ST_SUM) && (cnt_r == CNT_W'(wks_pkg::NUM_KEYS)) &&
                  (!out_valid_r || !out_stall);

  always_comb begin
    ld.pos    = wks_pkg::POS_W'(32'(in_data.char_pos));
    ld.chr    = in_data.byte_value;
    ld.weight = in_data.weight;
    ld.len    = (32'(in_data.key_length) > wks_pkg::KEY_LEN_MAX) ?
                wks_pkg::LEN_W'(wks_pkg::KEY_LEN_MAX) :
                wks_pkg::LEN_W'(in_data.key_length);
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < wks_pkg::NUM_KEYS; i++) begin : g_cell
    always_comb begin
      ctl[i].char_we  = in_acc && (in_data.op == wks_pkg::OP_CHAR) &&
                        (32'(in_data.entry_index) == i) &&
                        (32'(in_data.char_pos) < wks_pkg::KEY_LEN_MAX);
      ctl[i].hdr_we   = in_acc && (in_data.op == wks_pkg::OP_HDR) &&
                        (32'(in_data.entry_index) == i);
      ctl[i].match_en = match_pend_r;
      ctl[i].active   = (32'(key_count_r) > i);
      ctl[i].clear    = finish;
    end

    wks_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl[i]),
      .ld         (ld),
      .win        (win_r),
      .chars_seen (chars_seen_r),
      .sum_in     (chain[i]),
      .sum_out    (chain[i+1])
    );
  end

  assign total = chain[wks_pkg::NUM_KEYS];

  always_comb begin
    if (total > SAT_HI) begin
      score_sat = 24'sd8388607;
    end else if (total < SAT_LO) begin
      score_sat = -24'sd8388608;
    end else begin
      score_sat = 24'(total);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && is_text && in_data.is_last) begin
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_nxt = ST_SUM;
        cnt_nxt   = '0;
      end
      ST_SUM: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end else if (cnt_r != CNT_W'(wks_pkg::NUM_KEYS)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      match_pend_r <= 1'b0;
      threshold_r  <= '0;
      key_count_r  <= '0;
      chars_seen_r <= '0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < wks_pkg::KEY_LEN_MAX; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      match_pend_r <= in_acc && is_text;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          wks_pkg::CFG_THRESHOLD: threshold_r <= cfg_data;
          wks_pkg::CFG_KEY_COUNT: key_count_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (finish) begin
        chars_seen_r <= '0;
        for (int k = 0; k < wks_pkg::KEY_LEN_MAX; k++) begin
          win_r[k] <= '0;
        end
      end else if (in_acc && is_text) begin
        win_r[0] <= folded;
        for (int k = 1; k < wks_pkg::KEY_LEN_MAX; k++) begin
          win_r[k] <= win_r[k-1];
        end
        if (chars_seen_r != wks_pkg::LEN_W'(wks_pkg::KEY_LEN_MAX)) begin
          chars_seen_r <= chars_seen_r + wks_pkg::LEN_W'(1);
        end
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_r.score    <= score_sat;
      out_r.selected <= (score_sat >= threshold_r);
    end
  end

  a_rise_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_SUM))
    else $error("result appeared without a summing pass");

  a_stall_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM || state_r == ST_MATCH) |-> in_stall)
    else $error("input taken while a record is being scored");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    chars_seen_r <= wks_pkg::LEN_W'(wks_pkg::KEY_LEN_MAX))
    else $error("window fill count out of range");

  a_match_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_text && in_data.is_last) |=> (state_r == ST_MATCH && match_pend_r))
    else $error("last byte not followed by its match cycle");

endmodule
